[rtl/grid_a_star_path_search_top_defines.svh]
// assertion macros shared by the checker of the grid path search block
// used by rtl/gastar_checker.sv; needs clk and rst_n in the including scope
`ifndef GRID_A_STAR_PATH_SEARCH_TOP_DEFINES_SVH
`define GRID_A_STAR_PATH_SEARCH_TOP_DEFINES_SVH

// check a property while out of reset
`define GASTAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define GASTAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gastar_pkg.sv]
// types, constants and helper functions of the grid path search block
// no dependencies; used by every rtl module
`default_nettype none

package gastar_pkg;

    localparam int ROW_W  = 6;
    localparam int CFG_W  = 7;
    localparam int COST_W = 17;

    // largest grid side held in storage
    localparam int MAX_SIDE = 64;

    localparam logic [COST_W-1:0] UNREACHED = 17'h1FFFF;
    localparam logic [CFG_W-1:0]  SIDE_RESET = 7'd64;

    // opcodes of a request
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ROW_W-1:0] cell_row;
        logic [ROW_W-1:0] cell_col;
        logic [7:0]       cell_value;
        logic [ROW_W-1:0] origin_row;
        logic [ROW_W-1:0] origin_col;
        logic [ROW_W-1:0] target_row;
        logic [ROW_W-1:0] target_col;
    } in_item_t;

    typedef struct packed {
        logic             search_found;
        logic             cell_valid;
        logic [ROW_W-1:0] path_row;
        logic [ROW_W-1:0] path_col;
        logic             path_last;
    } out_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } coord_t;

    // one grid node in the node memory
    typedef struct packed {
        logic              wall;
        logic              mark;
        logic [COST_W-1:0] cost;
        logic [COST_W-1:0] est;
        coord_t            from;
    } node_word_t;

    // neighbor step result
    typedef struct packed {
        logic            in_grid;
        coord_t          pos;
        logic [COST_W:0] nd;
        logic [COST_W:0] est;
    } step_t;

    function automatic logic signed [1:0] step_row_delta(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd1, 3'd4, 3'd5: v = 2'sb01;
            3'd3, 3'd6, 3'd7: v = 2'sb11;
            default:          v = 2'sb00;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] step_col_delta(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd4, 3'd6: v = 2'sb01;
            3'd2, 3'd5, 3'd7: v = 2'sb11;
            default:          v = 2'sb00;
        endcase
        return v;
    endfunction

    // straight steps first, diagonals after
    function automatic logic [3:0] step_cost(input logic [2:0] d);
        return d[2] ? 4'd14 : 4'd10;
    endfunction

    function automatic logic [ROW_W-1:0] abs_diff(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[rtl/gastar_step.sv]
// neighbor step unit: position, bounds check, tentative cost and estimate
// depends on gastar_pkg
`default_nettype none

module gastar_step (
    input  gastar_pkg::coord_t               node,
    input  logic [2:0]                       dir,
    input  logic [gastar_pkg::CFG_W-1:0]     rows,
    input  logic [gastar_pkg::CFG_W-1:0]     cols,
    input  gastar_pkg::coord_t               target,
    input  logic [gastar_pkg::COST_W-1:0]    cost,
    output gastar_pkg::step_t                step
);

    logic signed [7:0] r;
    logic signed [7:0] c;
    logic signed [1:0] dr;
    logic signed [1:0] dc;

    // neighbor position
    always_comb
    begin
        dr = gastar_pkg::step_row_delta(dir);
        dc = gastar_pkg::step_col_delta(dir);
        r  = $signed({2'b00, node.row}) + 8'(dr);
        c  = $signed({2'b00, node.col}) + 8'(dc);
    end

    // bounds, cost and estimate
    always_comb
    begin
        step.in_grid = !r[7] && (r[6:0] < rows) && !c[7] && (c[6:0] < cols);
        step.pos.row = r[5:0];
        step.pos.col = c[5:0];
        step.nd      = 18'(cost) + 18'(gastar_pkg::step_cost(dir));
        step.est     = step.nd
                     + 18'(gastar_pkg::abs_diff(r[5:0], target.row))
                     + 18'(gastar_pkg::abs_diff(c[5:0], target.col));
    end

endmodule

`default_nettype wire

[rtl/grid_a_star_path_search_top.sv]
// Grid path search on an 8-connected map.
// Requests enter on in_valid/in_stall with an in_item_t payload; results
// leave on out_valid/out_stall as out_item_t from an output register.
// A map load (opcode 0) gives no result; loads can be taken back to back,
// also while a result waits on a stalled output. A path read (opcode 2)
// gives its result from the S_PATH state, or straight from idle when no
// path cell remains; the next request waits while a read is in S_PATH.
// A start (opcode 1) first sweeps the node memory (2**(2*log2 MAX_SIDE)
// entries, 4096 at the default), then runs the search: it scans the open
// list for the lowest estimate, closes that node, shifts the list to close
// the gap and relaxes its neighbors in the grid one at a time, until the
// target is picked or the list is empty. in_stall stays high for the
// whole search; the result follows it. After reset the block sweeps the
// node memory once to clear the wall map, with in_stall high;
// configuration writes are taken at any time. A stalled result holds its
// value; a start or read waits while the output register is full and
// stalled. Depends on gastar_pkg and gastar_step.
`default_nettype none

module grid_a_star_path_search_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  gastar_pkg::in_item_t         in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output gastar_pkg::out_item_t        out_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [gastar_pkg::CFG_W-1:0] cfg_data
);

    localparam int SIDE_W = $clog2(gastar_pkg::MAX_SIDE);
    localparam int ADDR_W = 2 * SIDE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [gastar_pkg::CFG_W-1:0] SIDE_MAX =
        gastar_pkg::CFG_W'(gastar_pkg::MAX_SIDE);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLEAR  = 11'b00000000010,
        S_INIT   = 11'b00000000100,
        S_SCAN   = 11'b00000001000,
        S_PICK   = 11'b00000010000,
        S_SHIFT  = 11'b00000100000,
        S_NB_RD  = 11'b00001000000,
        S_NB_WR  = 11'b00010000000,
        S_FIN_RD = 11'b00100000000,
        S_FIN    = 11'b01000000000,
        S_PATH   = 11'b10000000000
    } state_t;

    function automatic logic [ADDR_W-1:0] node_addr(input gastar_pkg::coord_t p);
        return {p.row[SIDE_W-1:0], p.col[SIDE_W-1:0]};
    endfunction

    function automatic logic [gastar_pkg::CFG_W-1:0] clamp_side(
        input logic [gastar_pkg::CFG_W-1:0] v);
        logic [gastar_pkg::CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = gastar_pkg::CFG_W'(1);
        else if (v > SIDE_MAX)
            r = SIDE_MAX;
        return r;
    endfunction

    // registers
    state_t                          state_reg, state_next;
    logic [gastar_pkg::CFG_W-1:0]    rows_cfg_reg, rows_cfg_next;
    logic [gastar_pkg::CFG_W-1:0]    cols_cfg_reg, cols_cfg_next;
    logic [gastar_pkg::CFG_W-1:0]    nr_reg, nr_next;
    logic [gastar_pkg::CFG_W-1:0]    nc_reg, nc_next;
    gastar_pkg::coord_t              org_reg, org_next;
    gastar_pkg::coord_t              tgt_reg, tgt_next;
    logic                            bad_reg, bad_next;
    logic                            wall_clr_reg, wall_clr_next;
    logic [ADDR_W-1:0]               clr_reg, clr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                k_reg, k_next;
    logic                            v1_reg, v1_next;
    logic [CNT_W-1:0]                k1_reg, k1_next;
    logic                            v2_reg, v2_next;
    logic [CNT_W-1:0]                k2_reg, k2_next;
    gastar_pkg::coord_t              n2_reg, n2_next;
    logic                            have_best_reg, have_best_next;
    logic [CNT_W-1:0]                best_k_reg, best_k_next;
    gastar_pkg::coord_t              best_node_reg, best_node_next;
    logic [gastar_pkg::COST_W-1:0]   best_est_reg, best_est_next;
    logic [gastar_pkg::COST_W-1:0]   best_cost_reg, best_cost_next;
    gastar_pkg::coord_t              node_reg, node_next;
    logic [gastar_pkg::COST_W-1:0]   g_reg, g_next;
    logic [2:0]                      dir_reg, dir_next;
    logic                            found_reg, found_next;
    gastar_pkg::coord_t              cursor_reg, cursor_next;
    logic                            out_valid_reg, out_valid_next;
    gastar_pkg::out_item_t           out_reg, out_next;

    // memories and their ports
    gastar_pkg::node_word_t          node_mem [DEPTH];
    gastar_pkg::coord_t              list_mem [DEPTH];
    gastar_pkg::node_word_t          node_q;
    gastar_pkg::coord_t              list_q;
    logic [ADDR_W-1:0]               node_raddr;
    logic [ADDR_W-1:0]               node_waddr;
    gastar_pkg::node_word_t          node_wdata;
    logic                            node_we_wall;
    logic                            node_we_mark;
    logic                            node_we_rest;
    logic [ADDR_W-1:0]               list_raddr;
    logic [ADDR_W-1:0]               list_waddr;
    gastar_pkg::coord_t              list_wdata;
    logic                            list_we;

    logic                            in_acc;
    logic                            out_acc;
    gastar_pkg::step_t               step;
    gastar_pkg::coord_t              req_org;
    gastar_pkg::coord_t              req_tgt;
    logic [gastar_pkg::CFG_W-1:0]    req_nr;
    logic [gastar_pkg::CFG_W-1:0]    req_nc;
    logic                            req_bad;

    // neighbor step unit
    gastar_step u_step (
        .node   (node_reg),
        .dir    (dir_reg),
        .rows   (nr_reg),
        .cols   (nc_reg),
        .target (tgt_reg),
        .cost   (g_reg),
        .step   (step)
    );

    // handshakes
    assign out_acc   = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE)
                    || (out_valid_reg && out_stall
                        && (in_data.opcode == gastar_pkg::OP_START
                            || in_data.opcode == gastar_pkg::OP_READ));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // start request decode
    always_comb
    begin
        req_nr      = clamp_side(rows_cfg_reg);
        req_nc      = clamp_side(cols_cfg_reg);
        req_org.row = in_data.origin_row;
        req_org.col = in_data.origin_col;
        req_tgt.row = in_data.target_row;
        req_tgt.col = in_data.target_col;
        req_bad     = ({1'b0, in_data.origin_row} >= req_nr)
                   || ({1'b0, in_data.origin_col} >= req_nc)
                   || ({1'b0, in_data.target_row} >= req_nr)
                   || ({1'b0, in_data.target_col} >= req_nc);
    end

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        rows_cfg_next  = rows_cfg_reg;
        cols_cfg_next  = cols_cfg_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        org_next       = org_reg;
        tgt_next       = tgt_reg;
        bad_next       = bad_reg;
        wall_clr_next  = wall_clr_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        v1_next        = 1'b0;
        k1_next        = k1_reg;
        v2_next        = 1'b0;
        k2_next        = k2_reg;
        n2_next        = n2_reg;
        have_best_next = have_best_reg;
        best_k_next    = best_k_reg;
        best_node_next = best_node_reg;
        best_est_next  = best_est_reg;
        best_cost_next = best_cost_reg;
        node_next      = node_reg;
        g_next         = g_reg;
        dir_next       = dir_reg;
        found_next     = found_reg;
        cursor_next    = cursor_reg;
        out_valid_next = out_valid_reg && !out_acc;
        out_next       = out_reg;

        node_raddr   = node_addr(cursor_reg);
        node_waddr   = clr_reg;
        node_wdata   = '0;
        node_we_wall = 1'b0;
        node_we_mark = 1'b0;
        node_we_rest = 1'b0;
        list_raddr   = k_reg[ADDR_W-1:0];
        list_waddr   = k1_reg[ADDR_W-1:0];
        list_wdata   = list_q;
        list_we      = 1'b0;

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == gastar_pkg::CFG_ROWS)
                rows_cfg_next = cfg_data;
            else
                cols_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.opcode)
                        gastar_pkg::OP_LOAD:
                        begin
                            if ((7'(in_data.cell_row) < SIDE_MAX)
                                && (7'(in_data.cell_col) < SIDE_MAX))
                            begin
                                node_waddr      = {in_data.cell_row[SIDE_W-1:0],
                                                   in_data.cell_col[SIDE_W-1:0]};
                                node_wdata.wall = (in_data.cell_value == 8'd1);
                                node_we_wall    = 1'b1;
                            end
                        end
                        gastar_pkg::OP_START:
                        begin
                            nr_next       = req_nr;
                            nc_next       = req_nc;
                            bad_next      = req_bad;
                            org_next      = req_bad ? '0 : req_org;
                            tgt_next      = req_tgt;
                            wall_clr_next = 1'b0;
                            clr_next      = '0;
                            state_next    = S_CLEAR;
                        end
                        gastar_pkg::OP_READ:
                        begin
                            if (found_reg && (cursor_reg != org_reg))
                            begin
                                node_raddr = node_addr(cursor_reg);
                                state_next = S_PATH;
                            end
                            else
                            begin
                                out_next       = '0;
                                out_next.search_found = found_reg;
                                out_next.path_last    = 1'b1;
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // sweep node memory: reset clears walls too, a start keeps the walls
            S_CLEAR:
            begin
                node_waddr      = clr_reg;
                node_wdata.wall = 1'b0;
                node_wdata.mark = 1'b0;
                node_wdata.cost = gastar_pkg::UNREACHED;
                node_wdata.est  = gastar_pkg::UNREACHED;
                node_we_wall    = wall_clr_reg;
                node_we_mark    = 1'b1;
                node_we_rest    = 1'b1;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    if (wall_clr_reg)
                        state_next = S_IDLE;
                    else if (bad_reg)
                    begin
                        found_next     = 1'b0;
                        cursor_next    = '0;
                        count_next     = '0;
                        out_next       = '0;
                        out_next.path_last = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                        state_next = S_INIT;
                end
            end

            // seed origin
            S_INIT:
            begin
                node_waddr      = node_addr(org_reg);
                node_wdata.mark = 1'b1;
                node_wdata.cost = '0;
                node_wdata.est  = gastar_pkg::COST_W'(
                                  7'(gastar_pkg::abs_diff(org_reg.row, tgt_reg.row))
                                + 7'(gastar_pkg::abs_diff(org_reg.col, tgt_reg.col)));
                node_wdata.from = org_reg;
                node_we_mark    = 1'b1;
                node_we_rest    = 1'b1;
                list_waddr      = '0;
                list_wdata      = org_reg;
                list_we         = 1'b1;
                count_next      = CNT_W'(1);
                k_next          = '0;
                have_best_next  = 1'b0;
                state_next      = S_SCAN;
            end

            // pipelined minimum search over the open list
            S_SCAN:
            begin
                if (count_reg == '0)
                begin
                    found_next     = 1'b0;
                    cursor_next    = org_reg;
                    out_next       = '0;
                    out_next.path_last = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (k_reg < count_reg)
                    begin
                        list_raddr = k_reg[ADDR_W-1:0];
                        v1_next    = 1'b1;
                        k1_next    = k_reg;
                        k_next     = k_reg + 1'b1;
                    end
                    if (v1_reg)
                    begin
                        node_raddr = node_addr(list_q);
                        v2_next    = 1'b1;
                        k2_next    = k1_reg;
                        n2_next    = list_q;
                    end
                    if (v2_reg && (!have_best_reg || (node_q.est < best_est_reg)))
                    begin
                        have_best_next = 1'b1;
                        best_k_next    = k2_reg;
                        best_node_next = n2_reg;
                        best_est_next  = node_q.est;
                        best_cost_next = node_q.cost;
                    end
                    if ((k_reg >= count_reg) && !v1_reg && !v2_reg)
                        state_next = S_PICK;
                end
            end

            // close the chosen node or finish at the target
            S_PICK:
            begin
                if (best_node_reg == tgt_reg)
                begin
                    found_next = 1'b1;
                    if (tgt_reg == org_reg)
                    begin
                        cursor_next    = org_reg;
                        out_next       = '0;
                        out_next.search_found = 1'b1;
                        out_next.path_last    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                        state_next = S_FIN_RD;
                end
                else
                begin
                    node_waddr      = node_addr(best_node_reg);
                    node_wdata.mark = 1'b0;
                    node_we_mark    = 1'b1;
                    count_next      = count_reg - 1'b1;
                    k_next          = best_k_reg;
                    node_next       = best_node_reg;
                    g_next          = best_cost_reg;
                    state_next      = S_SHIFT;
                end
            end

            // close the gap in the open list
            S_SHIFT:
            begin
                if (k_reg < count_reg)
                begin
                    list_raddr = k_reg[ADDR_W-1:0] + 1'b1;
                    v1_next    = 1'b1;
                    k1_next    = k_reg;
                    k_next     = k_reg + 1'b1;
                end
                if (v1_reg)
                begin
                    list_waddr = k1_reg[ADDR_W-1:0];
                    list_wdata = list_q;
                    list_we    = 1'b1;
                end
                if ((k_reg >= count_reg) && !v1_reg)
                begin
                    dir_next   = '0;
                    state_next = S_NB_RD;
                end
            end

            // fetch neighbor entry
            S_NB_RD:
            begin
                if (step.in_grid)
                begin
                    node_raddr = node_addr(step.pos);
                    state_next = S_NB_WR;
                end
                else if (dir_reg == 3'd7)
                begin
                    k_next         = '0;
                    have_best_next = 1'b0;
                    state_next     = S_SCAN;
                end
                else
                    dir_next = dir_reg + 1'b1;
            end

            // relax neighbor
            S_NB_WR:
            begin
                if (!node_q.wall && (step.nd < 18'(gastar_pkg::UNREACHED))
                    && (step.nd < 18'(node_q.cost)))
                begin
                    node_waddr      = node_addr(step.pos);
                    node_wdata.mark = 1'b1;
                    node_wdata.cost = step.nd[gastar_pkg::COST_W-1:0];
                    node_wdata.est  = step.est[gastar_pkg::COST_W-1:0];
                    node_wdata.from = node_reg;
                    node_we_mark    = 1'b1;
                    node_we_rest    = 1'b1;
                    if (!node_q.mark)
                    begin
                        list_waddr = count_reg[ADDR_W-1:0];
                        list_wdata = step.pos;
                        list_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                if (dir_reg == 3'd7)
                begin
                    k_next         = '0;
                    have_best_next = 1'b0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = S_NB_RD;
                end
            end

            // first path cell is the target's predecessor
            S_FIN_RD:
            begin
                node_raddr = node_addr(tgt_reg);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                cursor_next    = node_q.from;
                out_next       = '0;
                out_next.search_found = 1'b1;
                out_next.path_last    = (node_q.from == org_reg);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            // step the path cursor one node back
            S_PATH:
            begin
                out_next.search_found = found_reg;
                out_next.cell_valid   = 1'b1;
                out_next.path_row     = cursor_reg.row;
                out_next.path_col     = cursor_reg.col;
                out_next.path_last    = (node_q.from == org_reg);
                out_valid_next = 1'b1;
                cursor_next    = node_q.from;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // node memory
    always_ff @(posedge clk)
    begin
        if (node_we_wall)
            node_mem[node_waddr].wall <= node_wdata.wall;
        if (node_we_mark)
            node_mem[node_waddr].mark <= node_wdata.mark;
        if (node_we_rest)
        begin
            node_mem[node_waddr].cost <= node_wdata.cost;
            node_mem[node_waddr].est  <= node_wdata.est;
            node_mem[node_waddr].from <= node_wdata.from;
        end
        node_q <= node_mem[node_raddr];
    end

    // open list memory
    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        list_q <= list_mem[list_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rows_cfg_reg  <= gastar_pkg::SIDE_RESET;
            cols_cfg_reg  <= gastar_pkg::SIDE_RESET;
            wall_clr_reg  <= 1'b1;
            clr_reg       <= '0;
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            have_best_reg <= 1'b0;
            found_reg     <= 1'b0;
            cursor_reg    <= '0;
            org_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            wall_clr_reg  <= wall_clr_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            have_best_reg <= have_best_next;
            found_reg     <= found_next;
            cursor_reg    <= cursor_next;
            org_reg       <= org_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nr_reg        <= nr_next;
        nc_reg        <= nc_next;
        tgt_reg       <= tgt_next;
        bad_reg       <= bad_next;
        k_reg         <= k_next;
        k1_reg        <= k1_next;
        k2_reg        <= k2_next;
        n2_reg        <= n2_next;
        best_k_reg    <= best_k_next;
        best_node_reg <= best_node_next;
        best_est_reg  <= best_est_next;
        best_cost_reg <= best_cost_next;
        node_reg      <= node_next;
        g_reg         <= g_next;
        dir_reg       <= dir_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

[rtl/gastar_checker.sv]
// port checker for the grid path search block, bound to the top level
// depends on gastar_pkg and grid_a_star_path_search_top_defines.svh
`default_nettype none

`include "grid_a_star_path_search_top_defines.svh"

module gastar_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire gastar_pkg::out_item_t out_data
);

    // a stalled result keeps its value
    `GASTAR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

    // a path cell only after a successful search
    `GASTAR_ASSERT(a_cell_found, out_valid && out_data.cell_valid |-> out_data.search_found, "path cell without found")

    // a result without a path cell carries a zero position
    `GASTAR_ASSERT(a_empty_zero, out_valid && !out_data.cell_valid |-> (out_data.path_row == '0) && (out_data.path_col == '0), "empty result malformed")

    // reset empties the output and starts the wall sweep
    `GASTAR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && in_stall, "busy output in reset")

endmodule

bind grid_a_star_path_search_top gastar_checker u_gastar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
